FILE: design/nglf_pkg.sv
// nglf_pkg: shared types and constants for the ngarch log-likelihood filter
// no dependencies

package nglf_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int CFG_IDX_W      = 2;
  localparam int REG_W          = 32;
  localparam int OUT_DATA_W     = 112;

  localparam logic [49:0] LOG_2PI_Q24 = 50'd30834461;
  localparam logic [63:0] LN2_Q28     = 64'd186065279;
  localparam logic signed [47:0] LL_MIN = 48'sh800000000000;

  typedef enum logic [1:0] {
    CFG_OMEGA    = 2'd0,
    CFG_ALPHA    = 2'd1,
    CFG_BETA     = 2'd2,
    CFG_LEVERAGE = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_DIV, ST_SQRT,
    ST_G2, ST_T, ST_D, ST_HDIV,
    ST_DZ, ST_SQ, ST_CO, ST_HR,
    ST_HCHK, ST_SQD, ST_Z, ST_NORM,
    ST_LSQ, ST_LM, ST_LN, ST_ACC, ST_DONE
  } state_t;

endpackage

FILE: design/ngarch_likelihood_filter.sv
// ngarch_likelihood_filter: top level, ngarch(1,1) variance recursion and log-likelihood
// depends on nglf_pkg; one shared 32x32 multiplier plus a one-bit-per-cycle div/sqrt step
// flow: the first item of a series adds a 64-step divide for the initial variance; the log
//   normalize shifts the variance until its top bit is set
// handshake: one item at a time, in_tready high only while idle; an item of a broken series
//   or with a variance fault ends early; a full output slot holds the finished item until taken
// reset: synchronous active-low rst_n clears state, config, series state and out_tvalid

module ngarch_likelihood_filter #(
  parameter int DATA_WIDTH = nglf_pkg::DATA_WIDTH_DEF,
  localparam int IN_W = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nglf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nglf_pkg::REG_W-1:0]    cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,   // return_value
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [nglf_pkg::OUT_DATA_W-1:0] out_tdata, // cond_variance, residual, log_likelihood
  output logic                          out_tlast,
  output logic                          out_tuser   // series_valid
);

  localparam logic signed [49:0] LOG_2PI_Q24_S = nglf_pkg::LOG_2PI_Q24;

  nglf_pkg::state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [31:0]  omega_r, alpha_r, beta_r, lev_r;
  logic signed [31:0] x_r, x_nxt;
  logic         last_r, last_nxt;
  logic [63:0]  mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt, prod_r, prod_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [63:0]  num_r, num_nxt;
  logic [31:0]  den_r, den_nxt, rem_r, rem_nxt;
  logic [63:0]  sqn_r, sqn_nxt, sqr_r, sqr_nxt, sqb_r, sqb_nxt;
  logic [63:0]  h_r, h_nxt;
  logic [31:0]  s_r, s_nxt, ly_r, ly_nxt;
  logic [4:0]   p_r, p_nxt, fidx_r, fidx_nxt;
  logic [29:0]  frac_r, frac_nxt;
  logic         lneg_r, lneg_nxt;
  logic signed [49:0] ln_r, ln_nxt;
  logic [31:0]  var_r, var_nxt, res_r, res_nxt;
  logic signed [47:0] sum_r, sum_nxt;
  logic         in_series_r, in_series_nxt, broken_r, broken_nxt;
  logic         out_valid_r, out_valid_nxt, out_last_r, out_last_nxt, out_user_r, out_user_nxt;
  logic [nglf_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic signed [DATA_WIDTH-1:0] xin;
  logic signed [63:0] x64;
  logic signed [31:0] xcl;
  logic [31:0]  glev_mag;
  logic signed [36:0] dz;
  logic [36:0]  dz_mag;
  logic signed [41:0] dval;
  logic [31:0]  a_limb, b_limb;
  logic [1:0]   pc;
  logic [6:0]   shamt;
  logic [32:0]  dshift;
  logic [63:0]  sq_try;
  logic signed [57:0] zq, zval;
  logic [57:0]  zmag;
  logic [32:0]  yq;
  logic [34:0]  mval;
  logic signed [49:0] term, nsum;
  logic signed [47:0] half;

  assign xin = in_tdata[DATA_WIDTH-1:0];
  assign x64 = 64'(xin);
  always_comb begin
    if (x64 > 64'sd2147483647) begin
      xcl = 32'sh7FFFFFFF;
    end else if (x64 < -64'sd2147483648) begin
      xcl = 32'sh80000000;
    end else begin
      xcl = x64[31:0];
    end
  end

  assign glev_mag = lev_r[31] ? 32'(-lev_r) : lev_r;
  assign dz       = {{5{res_r[31]}}, res_r} * 37'sd16 - 37'(signed'(lev_r));
  assign dz_mag   = dz[36] ? 37'(-dz) : 37'(dz);
  assign dval     = 42'sd1073741824 - 42'(beta_r) - 42'(acc_r[30 +: 40]);
  assign a_limb   = cnt_r[1] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_limb   = cnt_r[0] ? mul_b_r[63:32] : mul_b_r[31:0];
  assign pc       = cnt_r[1:0] - 2'd1;
  assign shamt    = (7'(pc[1]) + 7'(pc[0])) << 5;
  assign dshift   = {rem_r, num_r[63]};
  assign sq_try   = sqr_r + sqb_r;
  assign zq       = x_r[31] ? -58'(num_r) : 58'(num_r);
  assign zval     = zq + 58'(s_r >> 5);
  assign zmag     = zval[57] ? 58'(-zval) : 58'(zval);
  assign yq       = acc_r[31 +: 33];
  assign mval     = (p_r >= 5'd28) ? (35'(p_r - 5'd28) << 30) + 35'(frac_r)
                                   : (35'(5'd28 - p_r) << 30) - 35'(frac_r);
  assign term     = 50'(LOG_2PI_Q24_S) + ln_r + 50'(acc_r[24 +: 40]);
  assign nsum     = 50'(sum_r) + term;
  assign half     = (sum_r + $signed(48'(sum_r[47]))) >>> 1;

  assign in_tready  = (state_r == nglf_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; cnt_nxt = cnt_r;
    x_nxt = x_r; last_nxt = last_r;
    mul_a_nxt = mul_a_r; mul_b_nxt = mul_b_r; prod_nxt = prod_r; acc_nxt = acc_r;
    num_nxt = num_r; den_nxt = den_r; rem_nxt = rem_r;
    sqn_nxt = sqn_r; sqr_nxt = sqr_r; sqb_nxt = sqb_r;
    h_nxt = h_r; s_nxt = s_r; ly_nxt = ly_r; p_nxt = p_r; fidx_nxt = fidx_r;
    frac_nxt = frac_r; lneg_nxt = lneg_r; ln_nxt = ln_r;
    var_nxt = var_r; res_nxt = res_r; sum_nxt = sum_r;
    in_series_nxt = in_series_r; broken_nxt = broken_r;
    out_valid_nxt = out_valid_r; out_last_nxt = out_last_r; out_user_nxt = out_user_r;
    out_data_nxt = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      nglf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          x_nxt = xcl;
          last_nxt = in_tlast;
          if (broken_r) begin
            state_nxt = nglf_pkg::ST_DONE;
          end else if (!in_series_r) begin
            state_nxt = nglf_pkg::ST_G2;
          end else begin
            state_nxt = nglf_pkg::ST_DZ;
          end
        end
      end
      nglf_pkg::ST_MUL: begin
        if (cnt_r <= 6'd3) begin
          prod_nxt = a_limb * b_limb;
        end
        if (cnt_r != 6'd0) begin
          acc_nxt = acc_r + ({64'd0, prod_r} << shamt);
        end
        if (cnt_r == 6'd4) begin
          state_nxt = ret_r;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      nglf_pkg::ST_DIV: begin
        if (dshift >= {1'b0, den_r}) begin
          rem_nxt = 32'(dshift - {1'b0, den_r});
          num_nxt = {num_r[62:0], 1'b1};
        end else begin
          rem_nxt = dshift[31:0];
          num_nxt = {num_r[62:0], 1'b0};
        end
        if (cnt_r == 6'd63) begin
          state_nxt = ret_r;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      nglf_pkg::ST_SQRT: begin
        if (sqn_r >= sq_try) begin
          sqn_nxt = sqn_r - sq_try;
          sqr_nxt = (sqr_r >> 1) + sqb_r;
        end else begin
          sqr_nxt = sqr_r >> 1;
        end
        sqb_nxt = sqb_r >> 2;
        if (cnt_r == 6'd31) begin
          state_nxt = ret_r;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      nglf_pkg::ST_G2: begin
        mul_a_nxt = 64'(glev_mag); mul_b_nxt = 64'(glev_mag);
        acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = nglf_pkg::ST_T; state_nxt = nglf_pkg::ST_MUL;
      end
      nglf_pkg::ST_T: begin
        mul_a_nxt = 64'(alpha_r);
        mul_b_nxt = 64'd1073741824 + 64'(acc_r[26 +: 40]);
        acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = nglf_pkg::ST_D; state_nxt = nglf_pkg::ST_MUL;
      end
      nglf_pkg::ST_D: begin
        if (dval <= 42'sd0) begin
          h_nxt = '0;
          state_nxt = nglf_pkg::ST_HCHK;
        end else begin
          num_nxt = {4'd0, omega_r, 28'd0};
          den_nxt = dval[31:0];
          rem_nxt = '0; cnt_nxt = '0;
          ret_nxt = nglf_pkg::ST_HDIV; state_nxt = nglf_pkg::ST_DIV;
        end
      end
      nglf_pkg::ST_HDIV: begin
        h_nxt = num_r;
        state_nxt = nglf_pkg::ST_HCHK;
      end
      nglf_pkg::ST_DZ: begin
        mul_a_nxt = 64'(dz_mag); mul_b_nxt = 64'(dz_mag);
        acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = nglf_pkg::ST_SQ; state_nxt = nglf_pkg::ST_MUL;
      end
      nglf_pkg::ST_SQ: begin
        mul_a_nxt = 64'(alpha_r); mul_b_nxt = 64'(acc_r[28 +: 48]);
        acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = nglf_pkg::ST_CO; state_nxt = nglf_pkg::ST_MUL;
      end
      nglf_pkg::ST_CO: begin
        mul_a_nxt = 64'(var_r);
        mul_b_nxt = 64'(beta_r) + 64'(acc_r[28 +: 52]);
        acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = nglf_pkg::ST_HR; state_nxt = nglf_pkg::ST_MUL;
      end
      nglf_pkg::ST_HR: begin
        h_nxt = (64'(omega_r) + acc_r[28 +: 64]) >> 2;
        state_nxt = nglf_pkg::ST_HCHK;
      end
      nglf_pkg::ST_HCHK: begin
        if (h_r == 64'd0) begin
          var_nxt = '0; res_nxt = '0; broken_nxt = 1'b1;
          state_nxt = nglf_pkg::ST_DONE;
        end else if (h_r[63:32] != 32'd0) begin
          var_nxt = 32'hFFFFFFFF; res_nxt = '0; broken_nxt = 1'b1;
          state_nxt = nglf_pkg::ST_DONE;
        end else begin
          sqn_nxt = {h_r[35:0], 28'd0};
          sqr_nxt = '0;
          sqb_nxt = 64'd1 << 62;
          cnt_nxt = '0;
          ret_nxt = nglf_pkg::ST_SQD; state_nxt = nglf_pkg::ST_SQRT;
        end
      end
      nglf_pkg::ST_SQD: begin
        s_nxt = sqr_r[31:0];
        num_nxt = {7'd0, (x_r[31] ? 32'(-x_r) : 32'(x_r)), 24'd0, 1'b0} >> 1;
        den_nxt = sqr_r[31:0];
        rem_nxt = '0; cnt_nxt = '0;
        ret_nxt = nglf_pkg::ST_Z; state_nxt = nglf_pkg::ST_DIV;
      end
      nglf_pkg::ST_Z: begin
        var_nxt = h_r[31:0];
        if (zval > 58'sd2147483647 || zval < -58'sd2147483648) begin
          res_nxt = zval[57] ? 32'h80000000 : 32'h7FFFFFFF;
          broken_nxt = 1'b1;
          state_nxt = nglf_pkg::ST_DONE;
        end else begin
          res_nxt = zval[31:0];
          ly_nxt = h_r[31:0];
          p_nxt = 5'd31;
          state_nxt = nglf_pkg::ST_NORM;
        end
      end
      nglf_pkg::ST_NORM: begin
        if (ly_r[31]) begin
          mul_a_nxt = 64'(ly_r); mul_b_nxt = 64'(ly_r);
          acc_nxt = '0; cnt_nxt = '0;
          frac_nxt = '0; fidx_nxt = 5'd29;
          ret_nxt = nglf_pkg::ST_LSQ; state_nxt = nglf_pkg::ST_MUL;
        end else begin
          ly_nxt = ly_r << 1;
          p_nxt = p_r - 5'd1;
        end
      end
      nglf_pkg::ST_LSQ: begin
        if (yq[32]) begin
          frac_nxt[fidx_r] = 1'b1;
          ly_nxt = yq[32:1];
        end else begin
          ly_nxt = yq[31:0];
        end
        if (fidx_r == 5'd0) begin
          state_nxt = nglf_pkg::ST_LM;
        end else begin
          fidx_nxt = fidx_r - 5'd1;
          mul_a_nxt = 64'(yq[32] ? yq[32:1] : yq[31:0]);
          mul_b_nxt = 64'(yq[32] ? yq[32:1] : yq[31:0]);
          acc_nxt = '0; cnt_nxt = '0;
          ret_nxt = nglf_pkg::ST_LSQ; state_nxt = nglf_pkg::ST_MUL;
        end
      end
      nglf_pkg::ST_LM: begin
        lneg_nxt = (p_r < 5'd28);
        mul_a_nxt = 64'(mval); mul_b_nxt = nglf_pkg::LN2_Q28;
        acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = nglf_pkg::ST_LN; state_nxt = nglf_pkg::ST_MUL;
      end
      nglf_pkg::ST_LN: begin
        ln_nxt = lneg_r ? -50'(acc_r[34 +: 30]) : 50'(acc_r[34 +: 30]);
        mul_a_nxt = 64'(zmag[31:0]); mul_b_nxt = 64'(zmag[31:0]);
        acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = nglf_pkg::ST_ACC; state_nxt = nglf_pkg::ST_MUL;
      end
      nglf_pkg::ST_ACC: begin
        if (nsum > 50'sd140737488355327 || nsum < -50'sd140737488355328) begin
          broken_nxt = 1'b1;
        end else begin
          sum_nxt = nsum[47:0];
        end
        state_nxt = nglf_pkg::ST_DONE;
      end
      nglf_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt = last_r;
          out_user_nxt = !broken_r;
          out_data_nxt[31:0] = var_r;
          out_data_nxt[63:32] = res_r;
          if (!last_r) begin
            out_data_nxt[111:64] = '0;
          end else if (broken_r) begin
            out_data_nxt[111:64] = nglf_pkg::LL_MIN;
          end else begin
            out_data_nxt[111:64] = -half;
          end
          if (last_r) begin
            in_series_nxt = 1'b0; broken_nxt = 1'b0; sum_nxt = '0;
          end else begin
            in_series_nxt = 1'b1;
          end
          state_nxt = nglf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nglf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nglf_pkg::ST_IDLE;
      ret_r <= nglf_pkg::ST_IDLE;
      omega_r <= '0; alpha_r <= '0; beta_r <= '0; lev_r <= '0;
      var_r <= '0; res_r <= '0; sum_r <= '0;
      in_series_r <= 1'b0; broken_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      var_r <= var_nxt; res_r <= res_nxt; sum_r <= sum_nxt;
      in_series_r <= in_series_nxt; broken_r <= broken_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (nglf_pkg::cfg_idx_t'(cfg_index))
          nglf_pkg::CFG_OMEGA:    omega_r <= cfg_wdata;
          nglf_pkg::CFG_ALPHA:    alpha_r <= cfg_wdata;
          nglf_pkg::CFG_BETA:     beta_r <= cfg_wdata;
          nglf_pkg::CFG_LEVERAGE: lev_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt; x_r <= x_nxt; last_r <= last_nxt;
    mul_a_r <= mul_a_nxt; mul_b_r <= mul_b_nxt; prod_r <= prod_nxt; acc_r <= acc_nxt;
    num_r <= num_nxt; den_r <= den_nxt; rem_r <= rem_nxt;
    sqn_r <= sqn_nxt; sqr_r <= sqr_nxt; sqb_r <= sqb_nxt;
    h_r <= h_nxt; s_r <= s_nxt; ly_r <= ly_nxt; p_r <= p_nxt; fidx_r <= fidx_nxt;
    frac_r <= frac_nxt; lneg_r <= lneg_nxt; ln_r <= ln_nxt;
    out_last_r <= out_last_nxt; out_user_r <= out_user_nxt; out_data_r <= out_data_nxt;
  end

endmodule

FILE: design/nglf_checker.sv
// nglf_checker: port-level assertions for ngarch_likelihood_filter
// depends on nglf_pkg; bound to the top level below

module nglf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [nglf_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again before item finished");

  a_broken_ll: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && !out_tuser |-> out_tdata[111:64] == nglf_pkg::LL_MIN)
    else $error("broken series did not report minimum log-likelihood");

  a_mid_ll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[111:64] == 48'd0)
    else $error("log-likelihood nonzero before end of series");

endmodule

bind ngarch_likelihood_filter nglf_checker u_nglf_checker (.*);
